>>> hw/rtl/rgb_to_hsv_converter_unit_defines.svh
// assertion helpers used by the converter top module
`ifndef RGB_TO_HSV_CONVERTER_UNIT_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define RHC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define RHC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rhc_pkg.sv
`default_nettype none

package rhc_pkg;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE,
        SEC_GREY
    } t_sector;

    localparam int HUE_W   = 15;
    localparam int SAT_W   = 13;
    localparam int VAL_W   = 8;
    localparam int OUT_W   = 40;

    // quotient layout of the two dividers
    localparam int SAT_Q_W    = 13;
    localparam int HUE_INT    = 4;
    localparam int HUE_FRAC   = 8;
    localparam int HUE_Q_W    = HUE_INT + HUE_FRAC;
    localparam int DIV_STAGES = SAT_Q_W;

    localparam logic [15:0] HUE_GREEN_BASE = 16'd7680;
    localparam logic [15:0] HUE_BLUE_BASE  = 16'd15360;
    localparam logic [15:0] HUE_FULL_TURN  = 16'd23040;

endpackage

`default_nettype wire

>>> hw/rtl/rhc_front.sv
`default_nettype none

module rhc_front
    import rhc_pkg::*;
#(
    parameter int CB = 8,
    parameter int PW = 3 * CB + 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [CB-1:0] i_red,
    input  wire logic [CB-1:0] i_green,
    input  wire logic [CB-1:0] i_blue,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [PW-1:0]      o_data   // hi, delta, 15*|diff|, neg, sector
);

    logic [CB-1:0]        hi;
    logic [CB-1:0]        lo;
    logic [CB-1:0]        delta;
    t_sector              sector;
    logic signed [CB:0]   diff;
    logic                 neg;
    logic [CB-1:0]        mag;
    logic [CB+3:0]        x15;

    logic                 r_vld;
    logic [PW-1:0]        r_data;

    always_comb begin
        hi = i_red;
        lo = i_red;
        if (i_green > hi) hi = i_green;
        if (i_blue > hi) hi = i_blue;
        if (i_green < lo) lo = i_green;
        if (i_blue < lo) lo = i_blue;
        delta = hi - lo;

        // ties go to red, then green
        if (delta == '0) begin
            sector = SEC_GREY;
        end else if (hi == i_red) begin
            sector = SEC_RED;
        end else if (hi == i_green) begin
            sector = SEC_GREEN;
        end else begin
            sector = SEC_BLUE;
        end

        unique case (sector)
            SEC_RED:   diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
            SEC_GREEN: diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
            SEC_BLUE:  diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
            default:   diff = '0;
        endcase

        neg = diff[CB];
        mag = neg ? CB'(-diff) : diff[CB-1:0];
        // 3840 = 15 * 256, the 256 comes out of the fractional divide steps
        x15 = ({4'b0, mag} << 4) - {4'b0, mag};
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= {sector, neg, x15, delta, hi};
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_data;

endmodule

`default_nettype wire

>>> hw/rtl/rhc_fifo.sv
`default_nettype none

module rhc_fifo
    import rhc_pkg::*;
#(
    parameter int W     = 31,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [W-1:0] i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [W-1:0]      o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rhc_back.sv
`default_nettype none

module rhc_back
    import rhc_pkg::*;
#(
    parameter int CB = 8,
    parameter int PW = 3 * CB + 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [PW-1:0] i_data,   // hi, delta, 15*|diff|, neg, sector
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [OUT_W-1:0]   o_data    // hue, saturation, value
);

    localparam int NS = DIV_STAGES;
    localparam int RW = CB + 5;

    logic [CB-1:0]   in_hi;
    logic [CB-1:0]   in_dlt;
    logic [CB+3:0]   in_x;
    logic            in_neg;
    t_sector         in_sec;

    logic [NS-1:0]      r_vld;
    logic [RW-1:0]      r_srem [NS];
    logic [RW-1:0]      r_hrem [NS];
    logic [SAT_Q_W-1:0] r_sq   [NS];
    logic [HUE_Q_W-1:0] r_hq   [NS];
    logic [CB-1:0]      r_hi   [NS];
    logic [CB-1:0]      r_dlt  [NS];
    logic [NS-1:0]      r_neg;
    t_sector            r_sec  [NS];

    logic [RW-1:0]      n_srem [NS];
    logic [RW-1:0]      n_hrem [NS];
    logic [SAT_Q_W-1:0] n_sq   [NS];
    logic [HUE_Q_W-1:0] n_hq   [NS];

    logic                r_out_vld;
    logic [OUT_W-1:0]    r_out_data;
    logic                adv;

    logic [15:0]         base;
    logic [15:0]         hue_full;
    logic [HUE_Q_W-1:0]  hq_last;
    logic [CB+VAL_W-1:0] hi_ext;
    logic [HUE_W-1:0]    hue;
    logic [SAT_W-1:0]    sat;
    logic [VAL_W-1:0]    val;

    assign {in_sec, in_neg, in_x, in_dlt, in_hi} = i_data;

    // whole back end moves together; stalls only when the output beat waits
    assign adv     = !r_out_vld || i_ready;
    assign o_ready = adv;

    for (genvar gs = 0; gs < NS; gs++) begin : g_stg
        logic [RW-1:0]      srem_in;
        logic [RW-1:0]      hrem_in;
        logic [SAT_Q_W-1:0] sq_in;
        logic [HUE_Q_W-1:0] hq_in;
        logic [CB-1:0]      hi_in;
        logic [CB-1:0]      dlt_in;
        logic [RW-1:0]      s_cmp;
        logic [RW-1:0]      h_cmp;
        logic [RW-1:0]      h_div;
        logic               s_ge;
        logic               h_ge;

        if (gs == 0) begin : g_head
            assign srem_in = RW'(in_dlt);
            assign hrem_in = RW'(in_x);
            assign sq_in   = '0;
            assign hq_in   = '0;
            assign hi_in   = in_hi;
            assign dlt_in  = in_dlt;
        end else begin : g_body
            assign srem_in = r_srem[gs-1];
            assign hrem_in = r_hrem[gs-1];
            assign sq_in   = r_sq[gs-1];
            assign hq_in   = r_hq[gs-1];
            assign hi_in   = r_hi[gs-1];
            assign dlt_in  = r_dlt[gs-1];
        end

        // saturation: first step gives the integer bit, the rest are fraction bits
        always_comb begin
            s_cmp      = (gs == 0) ? srem_in : (srem_in << 1);
            s_ge       = (s_cmp >= RW'(hi_in));
            n_srem[gs] = s_ge ? s_cmp - RW'(hi_in) : s_cmp;
            n_sq[gs]   = {sq_in[SAT_Q_W-2:0], s_ge};
        end

        // hue: four integer steps against a shifted divisor, then fraction steps
        always_comb begin
            if (gs < HUE_INT) begin
                h_cmp = hrem_in;
                h_div = RW'(dlt_in) << (HUE_INT - 1 - gs);
            end else begin
                h_cmp = hrem_in << 1;
                h_div = RW'(dlt_in);
            end
            h_ge = (h_cmp >= h_div);
            if (gs < HUE_Q_W) begin
                n_hrem[gs] = h_ge ? h_cmp - h_div : h_cmp;
                n_hq[gs]   = {hq_in[HUE_Q_W-2:0], h_ge};
            end else begin
                n_hrem[gs] = hrem_in;
                n_hq[gs]   = hq_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int s = 0; s < NS; s++) begin
                r_srem[s] <= n_srem[s];
                r_hrem[s] <= n_hrem[s];
                r_sq[s]   <= n_sq[s];
                r_hq[s]   <= n_hq[s];
            end
            r_hi[0]  <= in_hi;
            r_dlt[0] <= in_dlt;
            r_neg[0] <= in_neg;
            r_sec[0] <= in_sec;
            for (int s = 1; s < NS; s++) begin
                r_hi[s]  <= r_hi[s-1];
                r_dlt[s] <= r_dlt[s-1];
                r_neg[s] <= r_neg[s-1];
                r_sec[s] <= r_sec[s-1];
            end
        end
    end

    always_comb begin
        hq_last = r_hq[NS-1];
        unique case (r_sec[NS-1])
            SEC_GREEN: base = HUE_GREEN_BASE;
            SEC_BLUE:  base = HUE_BLUE_BASE;
            default:   base = '0;
        endcase
        if (!r_neg[NS-1]) begin
            hue_full = base + 16'(hq_last);
        end else if (base < 16'(hq_last)) begin
            // red sector gone negative wraps once
            hue_full = base + HUE_FULL_TURN - 16'(hq_last);
        end else begin
            hue_full = base - 16'(hq_last);
        end
        hi_ext = (CB + VAL_W)'(r_hi[NS-1]);
        val    = hi_ext[VAL_W-1:0];
        if (r_sec[NS-1] == SEC_GREY) begin
            hue = '0;
            sat = '0;
        end else begin
            hue = hue_full[HUE_W-1:0];
            sat = r_sq[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_vld[NS-1]) begin
            r_out_data <= OUT_W'({val, sat, hue});
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out_data;

endmodule

`default_nettype wire

>>> hw/rtl/rgb_to_hsv_converter_unit.sv
// rgb to hsv converter, one pixel per beat
// slave stream: i_s_axis_tdata carries red, green, blue of CHANNEL_BITS each,
//   zero padded to whole bytes
// master stream: o_m_axis_tdata carries hue (15 bits, 1/64 degree),
//   saturation (13 bits, 4096 = 1.0) and value (8 bits), padded to 40 bits
// throughput: one pixel per clock unless the output stalls, set by the 13-step
//   pipelined divider that runs the saturation and hue quotients side by side,
//   one quotient bit a stage (the 12-bit hue quotient idles in the last stage);
//   beat path: classify register, 2-entry queue, divider stages, output register
// the classify stage keeps taking pixels while the back end is stalled until
//   the queue fills; a stalled output beat freezes the whole divider pipeline
// reset clears all valid bits and the queue pointers and count; nothing else needs clearing
// grey and black pixels give hue 0 and saturation 0
`default_nettype none

`include "rgb_to_hsv_converter_unit_defines.svh"

module rgb_to_hsv_converter_unit
    import rhc_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    // red, green, blue from bit 0 up
    input  wire logic [((3*CHANNEL_BITS+7)/8)*8-1:0]    i_s_axis_tdata,
    output logic                                        o_m_axis_tvalid,
    input  wire logic                                   i_m_axis_tready,
    // hue, saturation, value from bit 0 up
    output logic [OUT_W-1:0]                            o_m_axis_tdata
);

    localparam int CB = CHANNEL_BITS;
    localparam int PW = 3 * CB + 7;

    logic          w_f_vld;
    logic          w_f_rdy;
    logic [PW-1:0] w_f_data;
    logic          w_q_vld;
    logic          w_q_rdy;
    logic [PW-1:0] w_q_data;
    logic          w_q_pop;
    logic          w_out_stall;
    logic          w_in_acc;
    logic          w_range_ok;

    rhc_front #(
        .CB (CB),
        .PW (PW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_red   (i_s_axis_tdata[CB-1:0]),
        .i_green (i_s_axis_tdata[2*CB-1:CB]),
        .i_blue  (i_s_axis_tdata[3*CB-1:2*CB]),
        .o_valid (w_f_vld),
        .i_ready (w_f_rdy),
        .o_data  (w_f_data)
    );

    rhc_fifo #(
        .W     (PW),
        .DEPTH (2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_vld),
        .o_ready (w_f_rdy),
        .i_data  (w_f_data),
        .o_valid (w_q_vld),
        .i_ready (w_q_rdy),
        .o_data  (w_q_data)
    );

    rhc_back #(
        .CB (CB),
        .PW (PW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_vld),
        .o_ready (w_q_rdy),
        .i_data  (w_q_data),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

    assign w_q_pop     = w_q_vld && w_q_rdy;
    assign w_out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_range_ok  = (o_m_axis_tdata[14:0] < 15'd23040)
                         && (o_m_axis_tdata[27:15] <= 13'd4096);

    `RHC_ASSERT_SAME(a_stall_holds_queue, w_out_stall, !w_q_pop, "queue popped while stalled")
    `RHC_ASSERT_NEXT(a_accept_lands, w_in_acc, w_f_vld, "accepted pixel not in classify stage")
    `RHC_ASSERT_SAME(a_out_range, o_m_axis_tvalid, w_range_ok, "hue or saturation out of range")

endmodule

`default_nettype wire
